// File: rtl/kct_pkg.sv
// Shared types and constants of the keyed cooldown table.
package kct_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int TABLE_DEPTH_MAX = 256;
    // Widths sized for the deepest table allowed.
    localparam int IDX_W     = 8;
    localparam int CNT_W     = 9;
    localparam int KEY_W     = 64;
    localparam int TIME_W    = 32;
    localparam int CNT_OUT_W = 5;
    localparam logic [CNT_W-1:0] CNT_SAT = 9'd31;
    localparam logic [TIME_W-1:0] DEFAULT_COOLDOWN_RST = 32'd3000;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_ADD  = 1'b1
    } t_op;

    // Item held at the top and shown to every cell.
    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] elapsed;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] cooldown;
    } t_item;

    // Status token handed from cell to cell.
    typedef struct packed {
        logic             vld;
        logic             present;
        logic             have_free;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] count;
    } t_tok;

endpackage

// File: rtl/keyed_cooldown_table_core.sv
// Keyed cooldown table: a chain of entry cells with item, result and config ports.
//
// Input items arrive on the s_axis channel: tuser carries the operation
// (tick or add), tdata the elapsed time, key and custom time. Each item gives
// one result on m_axis: added, table full and the number of entries in use.
// The cfg channel writes the default cooldown; it is always ready and should
// only be written while no item is in flight.
// An accepted item starts a status token that walks the chain of
// TABLE_DEPTH cells, one cell per cycle; each cell ages or checks its own
// entry as the token passes. An add is committed to the free entry when the
// token leaves the last cell. The result is registered in the output register
// after the token leaves the last cell, and a new item is accepted only after
// the previous result has left the chain, so the length of the cell chain sets the rate.
// A finished result waits in the output register, and one more in a hold
// register, so the next item is taken while the receiver stalls; the input
// only waits on the receiver when both are full.
// Reset empties the table, clears all handshakes and sets the default
// cooldown to 3000.
module keyed_cooldown_table_core #(
    parameter int TABLE_DEPTH = kct_pkg::TABLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // elapsed[31:0], key[95:32], custom_time[127:96]
    input  logic         s_axis_tuser,  // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,  // added[0], table_full[1], entries_in_use[6:2], zero[7]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data
);

    logic                       r_busy;
    logic                       r_start;
    logic                       r_out_valid;
    logic                       r_hold_valid;
    logic [7:0]                 r_out_data;
    logic [7:0]                 r_hold_data;
    logic [kct_pkg::TIME_W-1:0] r_cfg;
    kct_pkg::t_item             r_item;

    kct_pkg::t_tok              w_start_tok;
    kct_pkg::t_tok              w_tok [TABLE_DEPTH];
    kct_pkg::t_tok              w_fin;
    logic [TABLE_DEPTH-1:0]     w_tok_vld;
    logic [TABLE_DEPTH-1:0]     w_wr;

    logic                       w_accept;
    logic                       w_done;
    logic                       w_ins;
    logic                       w_full;
    logic                       w_out_free;
    logic [kct_pkg::CNT_W-1:0]  w_count;
    logic [kct_pkg::CNT_OUT_W-1:0] w_count_sat;
    logic [7:0]                 w_res;
    logic [kct_pkg::TIME_W-1:0] w_custom;

    assign s_axis_tready = !r_busy;
    assign o_cfg_ready   = 1'b1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_custom      = s_axis_tdata[127:96];

    always_comb begin
        w_start_tok     = '0;
        w_start_tok.vld = r_start;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        kct_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_item (r_item),
            .i_tok  ((g == 0) ? w_start_tok : w_tok[(g == 0) ? 0 : g - 1]),
            .i_wr   (w_wr[g]),
            .o_tok  (w_tok[g])
        );
        assign w_tok_vld[g] = w_tok[g].vld;
        assign w_wr[g]      = w_ins && (w_fin.free_idx == kct_pkg::IDX_W'(g));
    end

    assign w_fin  = w_tok[TABLE_DEPTH-1];
    assign w_done = w_fin.vld;
    assign w_ins  = w_done && (r_item.op == kct_pkg::OP_ADD) && !w_fin.present
                    && w_fin.have_free;
    assign w_full = w_done && (r_item.op == kct_pkg::OP_ADD) && !w_fin.present
                    && !w_fin.have_free;

    assign w_count     = w_fin.count + kct_pkg::CNT_W'(w_ins);
    assign w_count_sat = (w_count > kct_pkg::CNT_SAT) ? kct_pkg::CNT_SAT[4:0]
                                                      : w_count[4:0];
    assign w_res       = {1'b0, w_count_sat, w_full, w_ins};
    assign w_out_free  = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_start      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
            r_cfg        <= kct_pkg::DEFAULT_COOLDOWN_RST;
        end else begin
            r_start <= w_accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if ((w_done || r_hold_valid) && w_out_free) begin
                r_busy <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= w_done || r_hold_valid;
            end
            if (w_done && !w_out_free) begin
                r_hold_valid <= 1'b1;
            end else if (r_hold_valid && w_out_free) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.op       <= kct_pkg::t_op'(s_axis_tuser);
            r_item.elapsed  <= s_axis_tdata[31:0];
            r_item.key      <= s_axis_tdata[95:32];
            r_item.cooldown <= (w_custom == '0) ? r_cfg : w_custom;
        end
        if (w_done && !w_out_free) begin
            r_hold_data <= w_res;
        end
        if (w_out_free && (w_done || r_hold_valid)) begin
            r_out_data <= r_hold_valid ? r_hold_data : w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // At most one token is ever in the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_start, w_tok_vld}))
        else $error("more than one token in the cell chain");

    // A token only leaves the chain while an item is in flight.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_busy)
        else $error("token finished with no item in flight");

    // The hold register is only used behind a full output register.
    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> r_out_valid)
        else $error("hold register filled while output register empty");

    // An accepted item launches its token in the next cycle.
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_start && r_busy)
        else $error("accepted item did not launch a token");

    // A commit never coincides with a full flag and writes at most one entry.
    a_ins_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ins && w_full) && $onehot0(w_wr))
        else $error("conflicting commit of an add item");

endmodule

// File: rtl/kct_cell.sv
// One table entry with the stage of the status token that passes through it.
module kct_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kct_pkg::t_item i_item,
    input  kct_pkg::t_tok  i_tok,
    input  logic          i_wr,
    output kct_pkg::t_tok  o_tok
);

    logic                       r_valid;
    logic [kct_pkg::KEY_W-1:0]  r_key;
    logic [kct_pkg::TIME_W-1:0] r_remaining;
    kct_pkg::t_tok              r_tok;

    logic                       n_valid;
    logic [kct_pkg::TIME_W-1:0] n_remaining;
    kct_pkg::t_tok              n_tok;

    always_comb begin
        n_valid     = r_valid;
        n_remaining = r_remaining;
        n_tok       = i_tok;
        if (i_tok.vld) begin
            if (i_item.op == kct_pkg::OP_TICK) begin
                if (r_valid) begin
                    if (r_remaining < i_item.elapsed) begin
                        n_valid = 1'b0;
                    end else begin
                        n_remaining = r_remaining - i_item.elapsed;
                    end
                end
                n_tok.count = i_tok.count + kct_pkg::CNT_W'(n_valid);
            end else begin
                if (r_valid && (r_key == i_item.key)) begin
                    n_tok.present = 1'b1;
                end
                // The first free entry along the chain is the lowest-numbered one.
                if (!r_valid && !i_tok.have_free) begin
                    n_tok.have_free = 1'b1;
                    n_tok.free_idx  = kct_pkg::IDX_W'(CELL_IDX);
                end
                n_tok.count = i_tok.count + kct_pkg::CNT_W'(r_valid);
            end
        end
        if (i_wr) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_tok.vld <= n_tok.vld;
        end
        r_tok.present   <= n_tok.present;
        r_tok.have_free <= n_tok.have_free;
        r_tok.free_idx  <= n_tok.free_idx;
        r_tok.count     <= n_tok.count;
        if (i_wr) begin
            r_key       <= i_item.key;
            r_remaining <= i_item.cooldown;
        end else begin
            r_remaining <= n_remaining;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: tb/kct_checker.sv
// Checker for the keyed cooldown table: watches all three channels, predicts and compares.
module kct_checker #(
    parameter int TABLE_DEPTH = kct_pkg::TABLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [127:0] i_s_data,
    input  logic         i_s_user,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [7:0]   i_m_data,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [31:0]  i_cfg_data,
    output int           o_mismatches,
    output int           o_outstanding,
    output int           o_results,
    output int           o_full_drops,
    output int           o_repeat_keys
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                          added;
        logic                          table_full;
        logic [kct_pkg::CNT_OUT_W-1:0] in_use;
    } t_outcome;

    bit                         live [TABLE_DEPTH];
    logic [kct_pkg::KEY_W-1:0]  stored_key [TABLE_DEPTH];
    logic [kct_pkg::TIME_W-1:0] time_left [TABLE_DEPTH];
    logic [kct_pkg::TIME_W-1:0] default_cd;

    t_outcome pending_outcomes [$];
    int mismatches   = 0;
    int results      = 0;
    int full_drops   = 0;
    int repeat_keys  = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = pending_outcomes.size();
    assign o_results     = results;
    assign o_full_drops  = full_drops;
    assign o_repeat_keys = repeat_keys;

    // Ages the table on a tick, or looks the key up and inserts it on an add.
    task automatic age_or_insert(input kct_pkg::t_op op,
                                 input logic [kct_pkg::TIME_W-1:0] elapsed,
                                 input logic [kct_pkg::KEY_W-1:0] key,
                                 input logic [kct_pkg::TIME_W-1:0] custom,
                                 output t_outcome res);
        bit found;
        int slot;
        int n;
        found = 1'b0;
        slot  = -1;
        n     = 0;
        res   = '0;
        if (op == kct_pkg::OP_TICK) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (live[i]) begin
                    if (time_left[i] < elapsed) begin
                        live[i] = 1'b0;
                    end else begin
                        time_left[i] = time_left[i] - elapsed;
                    end
                end
            end
        end else begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (live[i]) begin
                    if (stored_key[i] == key) begin
                        found = 1'b1;
                    end
                end else if (slot < 0) begin
                    slot = i;
                end
            end
            if (found) begin
                repeat_keys++;
            end else if (slot >= 0) begin
                live[slot]       = 1'b1;
                stored_key[slot] = key;
                time_left[slot]  = (custom != '0) ? custom : default_cd;
                res.added        = 1'b1;
            end else begin
                res.table_full = 1'b1;
                full_drops++;
            end
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            n += live[i];
        end
        res.in_use = (n > 31) ? kct_pkg::CNT_OUT_W'(31) : kct_pkg::CNT_OUT_W'(n);
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                live[i] = 1'b0;
            end
            default_cd = kct_pkg::DEFAULT_COOLDOWN_RST;
            pending_outcomes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                default_cd = i_cfg_data;
            end
            if (i_s_valid && i_s_ready) begin
                age_or_insert(kct_pkg::t_op'(i_s_user), i_s_data[31:0], i_s_data[95:32],
                              i_s_data[127:96], want);
                pending_outcomes.push_back(want);
            end
            if (i_m_valid && i_m_ready) begin
                results++;
                got.added      = i_m_data[0];
                got.table_full = i_m_data[1];
                got.in_use     = i_m_data[6:2];
                if (pending_outcomes.size() == 0) begin
                    $error("result item arrived with no item waiting for it");
                    mismatches++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.added !== want.added) begin
                        $error("added: expected %0d, got %0d", want.added, got.added);
                        mismatches++;
                    end
                    if (got.table_full !== want.table_full) begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, got.table_full);
                        mismatches++;
                    end
                    if (got.in_use !== want.in_use) begin
                        $error("entries_in_use: expected %0d, got %0d",
                               want.in_use, got.in_use);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the keyed cooldown table testbench: clock, reset, stimulus and verdict.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = kct_pkg::TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;
    logic         s_axis_tuser  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic         i_cfg_valid   = 1'b0;
    logic         o_cfg_ready;
    logic [31:0]  i_cfg_data    = '0;

    int mismatches;
    int outstanding;
    int results;
    int full_drops;
    int repeat_keys;

    int  items_sent  = 0;
    int  ticks_sent  = 0;
    int  cfg_writes  = 0;
    int  cycle_count = 0;
    bit  hold_off    = 1'b0;
    logic [kct_pkg::KEY_W-1:0] key_pool [40];

    keyed_cooldown_table_core #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    kct_checker #(
        .TABLE_DEPTH (DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_valid     (s_axis_tvalid),
        .i_s_ready     (s_axis_tready),
        .i_s_data      (s_axis_tdata),
        .i_s_user      (s_axis_tuser),
        .i_m_valid     (m_axis_tvalid),
        .i_m_ready     (m_axis_tready),
        .i_m_data      (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_results     (results),
        .o_full_drops  (full_drops),
        .o_repeat_keys (repeat_keys)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(0, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 15);
        end
        return $urandom_range(20, 60);
    endfunction

    // Receiver: stretches that are always ready alternate with stretches of random stalls.
    initial begin
        int  stall_left;
        int  stretch_left;
        bit  calm;
        stall_left   = 0;
        stretch_left = 0;
        calm         = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(30, 300);
                calm         = ($urandom_range(0, 3) == 0);
            end
            stretch_left--;
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (calm || $urandom_range(0, 99) < 60) begin
                m_axis_tready <= 1'b1;
            end else begin
                stall_left = pick_pause();
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Long receiver hold-offs while the sender keeps offering items, so the block backs up.
    initial begin
        wait (items_sent >= 300);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off = 1'b0;
        wait (items_sent >= 1100);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Called just after a falling edge; returns at a falling edge.
    task automatic send_item(input kct_pkg::t_op op,
                             input logic [kct_pkg::TIME_W-1:0] elapsed,
                             input logic [kct_pkg::KEY_W-1:0] key,
                             input logic [kct_pkg::TIME_W-1:0] custom);
        bit steady;
        steady = ((items_sent / 64) % 3 == 0);
        s_axis_tuser  <= op;
        s_axis_tdata  <= {custom, key, elapsed};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (op == kct_pkg::OP_TICK) begin
            ticks_sent++;
        end
        @(negedge i_clk);
        if (!steady && $urandom_range(0, 1) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat (1 + pick_pause()) @(negedge i_clk);
        end
    endtask

    task automatic send_tick(input logic [kct_pkg::TIME_W-1:0] elapsed);
        send_item(kct_pkg::OP_TICK, elapsed, {$urandom, $urandom}, $urandom);
    endtask

    task automatic send_add(input logic [kct_pkg::KEY_W-1:0] key,
                            input logic [kct_pkg::TIME_W-1:0] custom);
        send_item(kct_pkg::OP_ADD, $urandom, key, custom);
    endtask

    // Lowers valid and waits until every result has been taken.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_default(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Keys come mostly from a pool of 8 to 40 keys, often larger than the table, so repeats and
    // full-table drops are frequent; times are small so ties with the elapsed time occur.
    task automatic random_item(input int pool_n);
        logic [kct_pkg::KEY_W-1:0]  key;
        logic [kct_pkg::TIME_W-1:0] t;
        int r;
        if ($urandom_range(0, 99) < 65) begin
            key = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                               : key_pool[$urandom_range(0, pool_n - 1)];
            r = $urandom_range(0, 99);
            if (r < 35) begin
                t = '0;
            end else if (r < 85) begin
                t = $urandom_range(1, 40);
            end else begin
                t = $urandom;
            end
            send_add(key, t);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                t = '0;
            end else if (r < 88) begin
                t = $urandom_range(1, 12);
            end else begin
                t = $urandom;
            end
            send_tick(t);
        end
    endtask

    initial begin
        logic [31:0] settings [PHASES];
        int pool_n;
        settings = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd7, $urandom, 32'd20,
                     32'h8000_0000, $urandom_range(0, 100)};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with the reset default cooldown.
        send_tick('0);
        send_add('0, '0);
        send_add({kct_pkg::KEY_W{1'b1}}, {kct_pkg::TIME_W{1'b1}});
        send_add('0, 32'd55);
        send_add(64'd5, 32'd10);
        send_tick(32'd10);             // the key at exactly the elapsed time survives at zero
        send_tick(32'd1);              // and goes now
        send_add(64'd7, 32'd1);        // takes the freed entry
        for (int i = 0; i < DEPTH - 3; i++) begin
            send_add(64'd100 + i, $urandom_range(1, 500));
        end
        send_add(64'd200, '0);         // dropped, table full
        send_add({kct_pkg::KEY_W{1'b1}}, '0);   // present while full: neither added nor full
        send_tick({kct_pkg::TIME_W{1'b1}});

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_default(settings[p]);
            if (settings[p] == '0) begin
                // A key stored with zero time outlives a zero tick but not a tick of one.
                send_add(64'hDEAD_BEEF_0000_0001, '0);
                send_tick('0);
                send_tick(32'd1);
            end
            pool_n = $urandom_range(8, 40);
            for (int k = 0; k < pool_n; k++) begin
                key_pool[k] = {$urandom, $urandom};
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item(pool_n);
            end
        end

        drain();
        repeat (DEPTH + 8) @(negedge i_clk);
        $display("Sent %0d items (%0d ticks) over %0d default-cooldown settings.",
                 items_sent, ticks_sent, cfg_writes);
        $display("Checked %0d results, %0d full-table drops, %0d repeated keys.",
                 results, full_drops, repeat_keys);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
